@@ hdl/ats_pkg.sv @@
`timescale 1ns / 1ps

package ats_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int PRICE_W        = 32;
    localparam int CFG_W          = 7;
    localparam int AGE_OUT_W      = 6;
    localparam int TREND_W        = 2;

    typedef logic [PRICE_W-1:0]          t_price;
    typedef logic [CFG_W-1:0]            t_cfg;
    typedef logic [AGE_OUT_W-1:0]        t_age_out;
    typedef logic signed [TREND_W-1:0]   t_trend;

    localparam t_cfg   CFG_RESET  = t_cfg'(14);
    localparam t_trend TREND_UP   = 2'sb01;
    localparam t_trend TREND_DOWN = 2'sb11;
    localparam t_trend TREND_FLAT = 2'sb00;

endpackage

@@ hdl/ats_bar_if.sv @@
`timescale 1ns / 1ps

interface ats_bar_if
    import ats_pkg::*;
();
    logic   valid;
    logic   ready;
    t_price bar_high;
    t_price bar_low;
    logic   restart;

    modport source (output valid, bar_high, bar_low, restart, input ready);
    modport sink (input valid, bar_high, bar_low, restart, output ready);
endinterface

@@ hdl/ats_trend_if.sv @@
`timescale 1ns / 1ps

interface ats_trend_if
    import ats_pkg::*;
();
    logic     valid;
    logic     ready;
    t_trend   trend;
    t_age_out bars_since_high;
    t_age_out bars_since_low;

    modport source (output valid, trend, bars_since_high, bars_since_low, input ready);
    modport sink (input valid, trend, bars_since_high, bars_since_low, output ready);
endinterface

@@ hdl/aroon_trend_sign.sv @@
`timescale 1ns / 1ps
// a request that completes a window sets r_start; its search token then passes every
//   cell of the row into the output register; other requests leave the block free
// throughput: one request per cycle while the window fills; after a window completes, no new
//   request is taken until the search token has left the cell row for the output register
// reset: synchronous active low; clears the fill count, tokens and output valid and sets the
//   window length to 14; stored bars are not cleared

module aroon_trend_sign
    import ats_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  t_cfg           i_cfg_data,
    ats_bar_if.sink        i_bar,
    ats_trend_if.source    o_trend
);

    localparam int AGE_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    t_cfg               r_window_len;
    logic [LEN_W-1:0]   r_fill;
    logic [LEN_W-1:0]   n_fill;
    logic [LEN_W-1:0]   w_fill_base;
    logic               r_busy;
    logic               r_start;
    logic               r_out_valid;
    t_trend             r_out_trend;
    t_age_out           r_out_age_hi;
    t_age_out           r_out_age_lo;

    logic [CMP_W-1:0]   w_cfg_ext;
    logic [CMP_W-1:0]   w_len_ext;
    logic [LEN_W-1:0]   w_len;
    logic               w_accept;
    logic               w_due;
    logic               w_adv;
    logic               w_last_valid;
    t_trend             n_trend;

    t_price             w_high [0:MAX_WINDOW-1];
    t_price             w_low  [0:MAX_WINDOW-1];
    logic [MAX_WINDOW-1:0] w_tok_valid;
    t_price             w_best_hi [0:MAX_WINDOW-1];
    t_price             w_best_lo [0:MAX_WINDOW-1];
    logic [AGE_W-1:0]   w_age_hi [0:MAX_WINDOW-1];
    logic [AGE_W-1:0]   w_age_lo [0:MAX_WINDOW-1];

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        w_cfg_ext = CMP_W'(r_window_len);
        if (w_cfg_ext == '0) begin
            w_len_ext = CMP_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_WINDOW)) begin
            w_len_ext = CMP_W'(MAX_WINDOW);
        end else begin
            w_len_ext = w_cfg_ext;
        end
        w_len = LEN_W'(w_len_ext);
    end

    assign w_accept     = i_bar.valid && i_bar.ready;
    assign i_bar.ready  = !r_busy;
    assign w_last_valid = w_tok_valid[MAX_WINDOW-1];
    assign w_adv        = !w_last_valid || !r_out_valid || o_trend.ready;

    always_comb begin
        w_fill_base = i_bar.restart ? '0 : r_fill;
        n_fill      = (w_fill_base < LEN_W'(MAX_WINDOW)) ? w_fill_base + LEN_W'(1)
                                                         : w_fill_base;
        w_due       = (n_fill >= w_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_window_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_start <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_start <= w_accept && w_due;
            if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_accept && w_due) begin
                r_busy <= 1'b1;
            end else if (w_last_valid && w_adv) begin
                r_busy <= 1'b0;
            end
        end
    end

    // cell row: cell k holds the bar of age k, the search token moves one cell a cycle unless the output stalls
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        t_price           w_in_high;
        t_price           w_in_low;
        logic             w_in_valid;
        t_price           w_in_best_hi;
        t_price           w_in_best_lo;
        logic [AGE_W-1:0] w_in_age_hi;
        logic [AGE_W-1:0] w_in_age_lo;

        if (k == 0) begin : g_head
            assign w_in_high    = i_bar.bar_high;
            assign w_in_low     = i_bar.bar_low;
            assign w_in_valid   = r_start;
            assign w_in_best_hi = '0;
            assign w_in_best_lo = '0;
            assign w_in_age_hi  = '0;
            assign w_in_age_lo  = '0;
        end else begin : g_body
            assign w_in_high    = w_high[k-1];
            assign w_in_low     = w_low[k-1];
            assign w_in_valid   = w_tok_valid[k-1];
            assign w_in_best_hi = w_best_hi[k-1];
            assign w_in_best_lo = w_best_lo[k-1];
            assign w_in_age_hi  = w_age_hi[k-1];
            assign w_in_age_lo  = w_age_lo[k-1];
        end

        ats_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .INDEX      (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_accept),
            .i_high      (w_in_high),
            .i_low       (w_in_low),
            .o_high      (w_high[k]),
            .o_low       (w_low[k]),
            .i_adv       (w_adv),
            .i_len       (w_len),
            .i_tok_valid (w_in_valid),
            .i_best_hi   (w_in_best_hi),
            .i_best_lo   (w_in_best_lo),
            .i_age_hi    (w_in_age_hi),
            .i_age_lo    (w_in_age_lo),
            .o_tok_valid (w_tok_valid[k]),
            .o_best_hi   (w_best_hi[k]),
            .o_best_lo   (w_best_lo[k]),
            .o_age_hi    (w_age_hi[k]),
            .o_age_lo    (w_age_lo[k])
        );
    end

    always_comb begin
        if (w_age_hi[MAX_WINDOW-1] < w_age_lo[MAX_WINDOW-1]) begin
            n_trend = TREND_UP;
        end else if (w_age_hi[MAX_WINDOW-1] > w_age_lo[MAX_WINDOW-1]) begin
            n_trend = TREND_DOWN;
        end else begin
            n_trend = TREND_FLAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last_valid && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_trend.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_valid && w_adv) begin
            r_out_trend  <= n_trend;
            r_out_age_hi <= AGE_OUT_W'(w_age_hi[MAX_WINDOW-1]);
            r_out_age_lo <= AGE_OUT_W'(w_age_lo[MAX_WINDOW-1]);
        end
    end

    assign o_trend.valid           = r_out_valid;
    assign o_trend.trend           = r_out_trend;
    assign o_trend.bars_since_high = r_out_age_hi;
    assign o_trend.bars_since_low  = r_out_age_lo;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one search token in the cell row");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok_valid != '0) |-> r_busy)
        else $error("search token present while block is free");

    a_out_from_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_last_valid))
        else $error("result appeared without a finished search");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_WINDOW))
        else $error("fill count beyond window capacity");

    a_start_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> w_tok_valid[0])
        else $error("search token lost at head cell");
`endif

endmodule

@@ hdl/ats_cell.sv @@
`timescale 1ns / 1ps

module ats_cell
    import ats_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int INDEX      = 0,
    localparam int AGE_W     = $clog2(MAX_WINDOW),
    localparam int LEN_W     = $clog2(MAX_WINDOW + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  t_price           i_high,
    input  t_price           i_low,
    output t_price           o_high,
    output t_price           o_low,
    input  logic             i_adv,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_tok_valid,
    input  t_price           i_best_hi,
    input  t_price           i_best_lo,
    input  logic [AGE_W-1:0] i_age_hi,
    input  logic [AGE_W-1:0] i_age_lo,
    output logic             o_tok_valid,
    output t_price           o_best_hi,
    output t_price           o_best_lo,
    output logic [AGE_W-1:0] o_age_hi,
    output logic [AGE_W-1:0] o_age_lo
);

    localparam bit IS_HEAD = (INDEX == 0);

    t_price             r_high;
    t_price             r_low;
    logic               r_tok_valid;
    t_price             r_best_hi;
    t_price             r_best_lo;
    logic [AGE_W-1:0]   r_age_hi;
    logic [AGE_W-1:0]   r_age_lo;

    logic               w_active;
    logic               w_upd_hi;
    logic               w_upd_lo;
    t_price             n_best_hi;
    t_price             n_best_lo;
    logic [AGE_W-1:0]   n_age_hi;
    logic [AGE_W-1:0]   n_age_lo;

    // older equal values win: scan runs newest to oldest and a later cell takes a tie
    always_comb begin
        w_active  = (LEN_W'(INDEX) < i_len);
        w_upd_hi  = IS_HEAD || (w_active && (r_high >= i_best_hi));
        w_upd_lo  = IS_HEAD || (w_active && (r_low <= i_best_lo));
        n_best_hi = w_upd_hi ? r_high : i_best_hi;
        n_best_lo = w_upd_lo ? r_low : i_best_lo;
        n_age_hi  = w_upd_hi ? AGE_W'(INDEX) : i_age_hi;
        n_age_lo  = w_upd_lo ? AGE_W'(INDEX) : i_age_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_high <= i_high;
            r_low  <= i_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_best_hi <= n_best_hi;
            r_best_lo <= n_best_lo;
            r_age_hi  <= n_age_hi;
            r_age_lo  <= n_age_lo;
        end
    end

    assign o_high      = r_high;
    assign o_low       = r_low;
    assign o_tok_valid = r_tok_valid;
    assign o_best_hi   = r_best_hi;
    assign o_best_lo   = r_best_lo;
    assign o_age_hi    = r_age_hi;
    assign o_age_lo    = r_age_lo;

endmodule
